FILE: sv/bba_pkg.sv
// bba_pkg: shared constants, codes and the metadata entry type of the buddy block allocator
// no dependencies; used by the channel interfaces, the engine and the top level

package bba_pkg;

   localparam int POOL_SLOTS    = 4096;
   localparam int INITIAL_SLOTS = 32;
   localparam int START_SLOTS   =
      ((INITIAL_SLOTS <= POOL_SLOTS) ? INITIAL_SLOTS : POOL_SLOTS) / 16 * 16;
   localparam int META_DEPTH    = POOL_SLOTS / 2;
   localparam int GRAN_W        = $clog2(META_DEPTH);
   localparam int REGION_W      = $clog2(POOL_SLOTS) + 1;
   localparam int IDX_W         = 12;
   localparam int CMD_W         = 2;
   localparam int CLS_W         = 2;
   localparam int STATUS_W      = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE_UPR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   localparam logic [CLS_W-1:0] CLS_TOP = 2'd3;

   // one entry per 2-slot granule, links are granule numbers
   typedef struct packed {
      logic              is_free;
      logic [CLS_W-1:0]  cls;
      logic              has_prev;
      logic              has_next;
      logic [GRAN_W-1:0] prev;
      logic [GRAN_W-1:0] next;
   } meta_type;

   localparam int META_W = $bits(meta_type);

   typedef struct packed {
      logic                done;
      logic [IDX_W-1:0]    allocated_index;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

FILE: sv/bba_channel_if.sv
// bba_req_if and bba_rsp_if: valid/ready channels of the buddy block allocator
// depends on bba_pkg for field widths

interface bba_req_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::CMD_W-1:0]    command;
   logic [bba_pkg::CLS_W-1:0]    size_class;
   logic [bba_pkg::IDX_W-1:0]    block_index;

   modport source (output valid, command, size_class, block_index, input ready);
   modport sink   (input valid, command, size_class, block_index, output ready);
endinterface

interface bba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::IDX_W-1:0]    allocated_index;
   logic [bba_pkg::STATUS_W-1:0] status;

   modport source (output valid, allocated_index, status, input ready);
   modport sink   (input valid, allocated_index, status, output ready);
endinterface

FILE: sv/buddy_block_allocator_top.sv
// buddy block allocator, one transaction in flight, one response per request
// alloc: when the region doubles, one metadata entry is written per new 16-slot block;
//   release: bounded by metadata ram reads (one read port, registered read data)
// clear: one metadata entry written per cycle; a new request is taken only when idle
// synchronous reset rebuilds all 2048 metadata ram entries, requests held off
// depends on bba_pkg, bba_channel_if, bba_engine

module buddy_block_allocator_top (
   input  logic           clock,
   input  logic           reset,
   bba_req_if.sink        req_if,
   bba_rsp_if.source      rsp_if
);

   bba_pkg::result_type             result;
   logic                            eng_idle;
   logic                            out_free;
   logic                            rsp_valid_ff;
   logic [bba_pkg::IDX_W-1:0]       rsp_index_ff;
   logic [bba_pkg::STATUS_W-1:0]    rsp_status_ff;

   // the response register frees the engine to take the next transaction
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = eng_idle;

   bba_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_if.valid && eng_idle),
      .command     (req_if.command),
      .size_class  (req_if.size_class),
      .block_index (req_if.block_index),
      .idle        (eng_idle),
      .out_free    (out_free),
      .result      (result)
   );

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_index_ff  <= result.allocated_index;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.allocated_index = rsp_index_ff;
   assign rsp_if.status          = rsp_status_ff;

endmodule

FILE: sv/bba_meta_ram.sv
// bba_meta_ram: generic single-write, single-read synchronous ram, registered read data
// no dependencies

module bba_meta_ram #(
   parameter int Depth = 2048,
   parameter int Width = 27
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: sv/bba_engine.sv
// bba_engine: command sequencer around the block metadata ram
// depends on bba_pkg and bba_meta_ram

module bba_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bba_pkg::CMD_W-1:0]    command,
   input  logic [bba_pkg::CLS_W-1:0]    size_class,
   input  logic [bba_pkg::IDX_W-1:0]    block_index,
   output logic                         idle,
   input  logic                         out_free,
   output bba_pkg::result_type          result
);

   typedef enum logic [17:0] {
      S_CLEAR     = 18'h00001,
      S_IDLE      = 18'h00002,
      S_CHECK     = 18'h00004,
      S_OVL_RD    = 18'h00008,
      S_OVL_CHK   = 18'h00010,
      S_MERGE_RD  = 18'h00020,
      S_MERGE_CHK = 18'h00040,
      S_UNL_RD    = 18'h00080,
      S_UNL_M     = 18'h00100,
      S_UNL_P     = 18'h00200,
      S_UNL_N     = 18'h00400,
      S_UNL_Z     = 18'h00800,
      S_SPLIT     = 18'h01000,
      S_PUSH      = 18'h02000,
      S_PUSH_H    = 18'h04000,
      S_PUSH_B    = 18'h08000,
      S_GROW      = 18'h10000,
      S_DONE      = 18'h20000
   } state_type;

   localparam int GW = bba_pkg::GRAN_W;
   localparam int RW = bba_pkg::REGION_W;

   // reset layout of one granule entry
   function automatic bba_pkg::meta_type init_entry(input logic [GW-1:0] g);
      bba_pkg::meta_type e;
      logic [RW-1:0]     s;
      e = '0;
      s = {1'b0, g, 1'b0};
      if (g[2:0] == 3'd0 && (s + RW'(16)) <= RW'(bba_pkg::START_SLOTS)) begin
         e.is_free  = 1'b1;
         e.cls      = bba_pkg::CLS_TOP;
         e.has_prev = (g != '0);
         e.prev     = (g != '0) ? g - GW'(8) : '0;
         e.has_next = (s + RW'(32)) <= RW'(bba_pkg::START_SLOTS);
         e.next     = e.has_next ? g + GW'(8) : '0;
      end
      return e;
   endfunction

   state_type                    state_ff, state_in;
   logic [bba_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [bba_pkg::CLS_W-1:0]    k_ff, k_in;
   logic [bba_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [bba_pkg::CLS_W-1:0]    lvl_ff, lvl_in;
   logic [GW-1:0]                b_ff, b_in;
   logic [GW-1:0]                ub_ff, ub_in;
   bba_pkg::meta_type            m_ff, m_in;
   logic [GW-1:0]                heads_ff [4];
   logic [GW-1:0]                heads_in [4];
   logic [3:0]                   hv_ff, hv_in;
   logic [RW-1:0]                region_ff, region_in;
   logic [GW-1:0]                og_ff, og_in;
   logic [bba_pkg::CLS_W-1:0]    oc_ff, oc_in;
   logic [3:0]                   ocnt_ff, ocnt_in;
   logic                         ph2_ff, ph2_in;
   logic [2:0]                   ol_ff, ol_in;
   logic [GW-1:0]                gi_ff, gi_in;
   logic [GW-1:0]                glo_ff, glo_in;
   logic [GW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic                         clr_rsp_ff, clr_rsp_in;
   logic [bba_pkg::IDX_W-1:0]    got_ff, got_in;
   logic [bba_pkg::STATUS_W-1:0] st_ff, st_in;

   logic                         mem_we;
   logic [GW-1:0]                mem_waddr;
   bba_pkg::meta_type            mem_wdata;
   logic [GW-1:0]                mem_raddr;
   logic [bba_pkg::META_W-1:0]   mem_rbits;
   bba_pkg::meta_type            rd;

   logic [4:0]                   blk_slots;
   logic                         bad_blk;
   logic [bba_pkg::IDX_W-1:0]    half_idx;
   logic                         fnd;
   logic [bba_pkg::CLS_W-1:0]    fnd_lvl;
   logic [GW-1:0]                ovl_base;
   logic [GW:0]                  ovl_end;

   bba_meta_ram #(
      .Depth (bba_pkg::META_DEPTH),
      .Width (bba_pkg::META_W)
   ) u_meta_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rbits)
   );

   assign rd   = bba_pkg::meta_type'(mem_rbits);
   assign idle = (state_ff == S_IDLE);

   // request checks and free-list search
   always_comb begin
      blk_slots = 5'd2 << k_ff;
      bad_blk   = ((idx_ff & {7'd0, blk_slots - 5'd1}) != '0) ||
                  (({1'b0, idx_ff} + {8'd0, blk_slots}) > region_ff);
      half_idx  = idx_ff + {7'd0, 5'd1 << k_ff};
      fnd       = 1'b0;
      fnd_lvl   = '0;
      for (int l = 3; l >= 0; l--) begin
         if (l >= int'(k_ff) && hv_ff[l]) begin
            fnd     = 1'b1;
            fnd_lvl = bba_pkg::CLS_W'(l);
         end
      end
      ovl_base = og_ff & ~((GW'(1) << ol_ff) - GW'(1));
      ovl_end  = {1'b0, ovl_base} + ((GW+1)'(1) << rd.cls);
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      lvl_in     = lvl_ff;
      b_in       = b_ff;
      ub_in      = ub_ff;
      m_in       = m_ff;
      heads_in   = heads_ff;
      hv_in      = hv_ff;
      region_in  = region_ff;
      og_in      = og_ff;
      oc_in      = oc_ff;
      ocnt_in    = ocnt_ff;
      ph2_in     = ph2_ff;
      ol_in      = ol_ff;
      gi_in      = gi_ff;
      glo_in     = glo_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      got_in     = got_ff;
      st_in      = st_ff;
      mem_we     = 1'b0;
      mem_waddr  = b_ff;
      mem_wdata  = '0;
      mem_raddr  = b_ff;
      result     = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = init_entry(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + GW'(1);
            if (clr_cnt_ff == GW'(bba_pkg::META_DEPTH - 1)) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in   = command;
               k_in     = size_class;
               idx_in   = block_index;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            got_in = '0;
            st_in  = bba_pkg::STATUS_OK;
            case (cmd_ff)
               bba_pkg::CMD_ALLOC: begin
                  if (fnd) begin
                     lvl_in   = fnd_lvl;
                     b_in     = heads_ff[fnd_lvl];
                     ub_in    = heads_ff[fnd_lvl];
                     state_in = S_UNL_RD;
                  end else if (region_ff != '0 &&
                               region_ff <= RW'(bba_pkg::POOL_SLOTS / 2)) begin
                     gi_in    = region_ff[GW:1];
                     glo_in   = region_ff[GW:1];
                     state_in = S_GROW;
                  end else begin
                     st_in    = bba_pkg::STATUS_OOM;
                     state_in = S_DONE;
                  end
               end
               bba_pkg::CMD_RELEASE: begin
                  if (bad_blk) begin
                     st_in    = bba_pkg::STATUS_BAD;
                     state_in = S_DONE;
                  end else begin
                     og_in    = idx_ff[GW:1];
                     oc_in    = k_ff;
                     ocnt_in  = '0;
                     ph2_in   = 1'b0;
                     ol_in    = {1'b0, k_ff} + 3'd1;
                     state_in = S_OVL_RD;
                  end
               end
               bba_pkg::CMD_RELEASE_UPR: begin
                  if (k_ff < 2'd2 || bad_blk) begin
                     st_in    = bba_pkg::STATUS_BAD;
                     state_in = S_DONE;
                  end else begin
                     og_in    = half_idx[GW:1];
                     oc_in    = k_ff - 2'd1;
                     ocnt_in  = '0;
                     ph2_in   = 1'b0;
                     ol_in    = {1'b0, k_ff};
                     state_in = S_OVL_RD;
                  end
               end
               default: begin
                  for (int l = 0; l < 4; l++) begin
                     heads_in[l] = '0;
                  end
                  hv_in      = (bba_pkg::START_SLOTS >= 16) ? 4'b1000 : 4'b0000;
                  region_in  = RW'(bba_pkg::START_SLOTS);
                  clr_cnt_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end
            endcase
         end
         // granules of the block itself, then enclosing free blocks
         S_OVL_RD: begin
            if (!ph2_ff) begin
               if (ocnt_ff == (4'd1 << oc_ff)) begin
                  ph2_in = 1'b1;
               end else begin
                  mem_raddr = og_ff + GW'(ocnt_ff);
                  state_in  = S_OVL_CHK;
               end
            end else if (ol_ff == 3'd4) begin
               b_in = og_ff;
               if (cmd_ff == bba_pkg::CMD_RELEASE) begin
                  lvl_in   = k_ff;
                  state_in = S_MERGE_RD;
               end else begin
                  lvl_in   = k_ff - 2'd1;
                  state_in = S_PUSH;
               end
            end else begin
               mem_raddr = ovl_base;
               state_in  = S_OVL_CHK;
            end
         end
         S_OVL_CHK: begin
            if (!ph2_ff) begin
               if (rd.is_free) begin
                  st_in    = bba_pkg::STATUS_BAD;
                  state_in = S_DONE;
               end else begin
                  ocnt_in  = ocnt_ff + 4'd1;
                  state_in = S_OVL_RD;
               end
            end else if (rd.is_free && ovl_end > {1'b0, og_ff}) begin
               st_in    = bba_pkg::STATUS_BAD;
               state_in = S_DONE;
            end else begin
               ol_in    = ol_ff + 3'd1;
               state_in = S_OVL_RD;
            end
         end
         S_MERGE_RD: begin
            if (lvl_ff == bba_pkg::CLS_TOP) begin
               state_in = S_PUSH;
            end else begin
               mem_raddr = b_ff ^ (GW'(1) << lvl_ff);
               state_in  = S_MERGE_CHK;
            end
         end
         S_MERGE_CHK: begin
            if (rd.is_free && rd.cls == lvl_ff) begin
               ub_in    = b_ff ^ (GW'(1) << lvl_ff);
               state_in = S_UNL_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_UNL_RD: begin
            mem_raddr = ub_ff;
            state_in  = S_UNL_M;
         end
         S_UNL_M: begin
            m_in = rd;
            if (rd.has_prev) begin
               mem_raddr = rd.prev;
               state_in  = S_UNL_P;
            end else begin
               hv_in[lvl_ff]    = rd.has_next;
               heads_in[lvl_ff] = rd.has_next ? rd.next : '0;
               if (rd.has_next) begin
                  mem_raddr = rd.next;
                  state_in  = S_UNL_N;
               end else begin
                  state_in = S_UNL_Z;
               end
            end
         end
         S_UNL_P: begin
            mem_we             = 1'b1;
            mem_waddr          = m_ff.prev;
            mem_wdata          = rd;
            mem_wdata.has_next = m_ff.has_next;
            mem_wdata.next     = m_ff.next;
            if (m_ff.has_next) begin
               mem_raddr = m_ff.next;
               state_in  = S_UNL_N;
            end else begin
               state_in = S_UNL_Z;
            end
         end
         S_UNL_N: begin
            mem_we             = 1'b1;
            mem_waddr          = m_ff.next;
            mem_wdata          = rd;
            mem_wdata.has_prev = m_ff.has_prev;
            mem_wdata.prev     = m_ff.prev;
            state_in           = S_UNL_Z;
         end
         S_UNL_Z: begin
            mem_we    = 1'b1;
            mem_waddr = ub_ff;
            mem_wdata = '0;
            if (cmd_ff == bba_pkg::CMD_ALLOC) begin
               state_in = S_SPLIT;
            end else begin
               b_in     = b_ff & ~(GW'(1) << lvl_ff);
               lvl_in   = lvl_ff + 2'd1;
               state_in = S_MERGE_RD;
            end
         end
         S_SPLIT: begin
            if (lvl_ff == k_ff) begin
               got_in   = {b_ff, 1'b0};
               state_in = S_DONE;
            end else begin
               lvl_in   = lvl_ff - 2'd1;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (hv_ff[lvl_ff]) begin
               mem_raddr = heads_ff[lvl_ff];
               state_in  = S_PUSH_H;
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = b_ff;
               mem_wdata.is_free = 1'b1;
               mem_wdata.cls     = lvl_ff;
               heads_in[lvl_ff]  = b_ff;
               hv_in[lvl_ff]     = 1'b1;
               if (cmd_ff == bba_pkg::CMD_ALLOC) begin
                  b_in     = b_ff + (GW'(1) << lvl_ff);
                  state_in = S_SPLIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_PUSH_H: begin
            mem_we             = 1'b1;
            mem_waddr          = heads_ff[lvl_ff];
            mem_wdata          = rd;
            mem_wdata.has_prev = 1'b1;
            mem_wdata.prev     = b_ff;
            state_in           = S_PUSH_B;
         end
         S_PUSH_B: begin
            mem_we             = 1'b1;
            mem_waddr          = b_ff;
            mem_wdata.is_free  = 1'b1;
            mem_wdata.cls      = lvl_ff;
            mem_wdata.has_next = 1'b1;
            mem_wdata.next     = heads_ff[lvl_ff];
            heads_in[lvl_ff]   = b_ff;
            if (cmd_ff == bba_pkg::CMD_ALLOC) begin
               b_in     = b_ff + (GW'(1) << lvl_ff);
               state_in = S_SPLIT;
            end else begin
               state_in = S_DONE;
            end
         end
         // chain the new upper half of the region as 16-slot blocks
         S_GROW: begin
            mem_we             = 1'b1;
            mem_waddr          = gi_ff;
            mem_wdata.is_free  = 1'b1;
            mem_wdata.cls      = bba_pkg::CLS_TOP;
            mem_wdata.has_prev = (gi_ff != glo_ff);
            mem_wdata.prev     = (gi_ff != glo_ff) ? gi_ff - GW'(8) : '0;
            mem_wdata.has_next = ({2'b0, gi_ff} + RW'(16)) <= region_ff;
            mem_wdata.next     = mem_wdata.has_next ? gi_ff + GW'(8) : '0;
            if (({2'b0, gi_ff} + RW'(16)) > region_ff) begin
               region_in   = {region_ff[RW-2:0], 1'b0};
               heads_in[3] = glo_ff;
               hv_in[3]    = 1'b1;
               lvl_in      = bba_pkg::CLS_TOP;
               b_in        = glo_ff;
               ub_in       = glo_ff;
               state_in    = S_UNL_RD;
            end else begin
               gi_in = gi_ff + GW'(8);
            end
         end
         S_DONE: begin
            if (out_free) begin
               result.done            = 1'b1;
               result.allocated_index = got_ff;
               result.status          = st_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         for (int l = 0; l < 4; l++) begin
            heads_ff[l] <= '0;
         end
         hv_ff      <= (bba_pkg::START_SLOTS >= 16) ? 4'b1000 : 4'b0000;
         region_ff  <= RW'(bba_pkg::START_SLOTS);
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         heads_ff   <= heads_in;
         hv_ff      <= hv_in;
         region_ff  <= region_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      lvl_ff  <= lvl_in;
      b_ff    <= b_in;
      ub_ff   <= ub_in;
      m_ff    <= m_in;
      og_ff   <= og_in;
      oc_ff   <= oc_in;
      ocnt_ff <= ocnt_in;
      ph2_ff  <= ph2_in;
      ol_ff   <= ol_in;
      gi_ff   <= gi_in;
      glo_ff  <= glo_in;
      got_ff  <= got_in;
      st_ff   <= st_in;
   end

endmodule
